/* rtl/core/assert_macros.svh */
// Assertion macros used by binary_gcd_lcm_unit.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/bgcd_pkg.sv */
package bgcd_pkg;

  localparam int FIELD_BITS = 63;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_BOTH_ZERO = 2'd2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] operand_a;
    logic [FIELD_BITS-1:0] operand_b;
  } bgcd_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] gcd_value;
    logic [FIELD_BITS-1:0] lcm_value;
    logic [1:0]            status;
  } bgcd_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STRIP,
    S_ODD,
    S_REDUCE,
    S_DIVIDE,
    S_MULT,
    S_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic strip_step;
    logic odd_step;
    logic reduce_step;
    logic div_init;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic out_load;
  } bgcd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic a_lsb;
    logic b_lsb;
    logic b_zero;
    logic op_zero;
    logic cnt_zero;
    logic out_free;
  } bgcd_stat_t;

endpackage

/* rtl/core/binary_gcd_lcm_unit.sv */
// Binary gcd / lcm unit.
// Input channel (in_valid/in_ready/in_data) takes operand_a and operand_b; only
// the low VALUE_BITS bits of each are used. Output channel
// (out_valid/out_ready/out_data) returns gcd_value, lcm_value and status for
// every input transaction, in order.
// One transaction is worked on at a time; in_ready is high only while the
// controller is idle. After acceptance, a transaction with an operand of zero
// goes straight to its result; otherwise the unit strips the common factors
// of two, then the other factors of two in operand_a, runs the subtract loop
// one step per cycle, then a bit-serial divider and a bit-serial multiplier.
// A result waits in an output register while the receiver stalls; the next
// transaction is accepted and computed meanwhile, and only its final load
// waits for the register to drain.
// Reset (rst, synchronous) returns the controller to idle and drops any
// pending result.
`include "assert_macros.svh"

module binary_gcd_lcm_unit #(
  parameter int VALUE_BITS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgcd_pkg::bgcd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bgcd_pkg::bgcd_out_t out_data
);
  import bgcd_pkg::*;

  localparam logic [FIELD_BITS-1:0] LCM_MAX = FIELD_BITS'({VALUE_BITS{1'b1}});

  bgcd_cmd_t  cmd;
  bgcd_stat_t stat;

  bgcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bgcd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_load_only_free, clk, rst, cmd.out_load, !out_valid || out_ready)
  `ASSERT_IMPLY(a_zero_result, clk, rst, out_valid && out_data.status == STATUS_BOTH_ZERO, out_data.gcd_value == '0 && out_data.lcm_value == '0)
  `ASSERT_IMPLY(a_sat_result, clk, rst, out_valid && out_data.status == STATUS_OVERFLOW, out_data.lcm_value == LCM_MAX)
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

/* rtl/core/bgcd_ctrl.sv */
module bgcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgcd_pkg::bgcd_stat_t stat,
  output bgcd_pkg::bgcd_cmd_t  cmd
);
  import bgcd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CHECK;
      S_CHECK:  state_next = stat.op_zero ? S_FINISH : S_STRIP;
      S_STRIP:  if (stat.a_lsb || stat.b_lsb) state_next = S_ODD;
      S_ODD:    if (stat.a_lsb) state_next = S_REDUCE;
      S_REDUCE: if (stat.b_zero) state_next = S_DIVIDE;
      S_DIVIDE: if (stat.cnt_zero) state_next = S_MULT;
      S_MULT:   if (stat.cnt_zero) state_next = S_FINISH;
      S_FINISH: if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: ;
      S_STRIP: cmd.strip_step = !(stat.a_lsb || stat.b_lsb);
      S_ODD:   cmd.odd_step = !stat.a_lsb;
      S_REDUCE: begin
        cmd.reduce_step = !stat.b_zero;
        cmd.div_init    = stat.b_zero;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        // last quotient bit: start the multiply in the same cycle
        cmd.mul_init = stat.cnt_zero;
      end
      S_MULT:   cmd.mul_step = 1'b1;
      S_FINISH: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/bgcd_datapath.sv */
module bgcd_datapath #(
  parameter int VALUE_BITS = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bgcd_pkg::bgcd_in_t   in_data,
  input  bgcd_pkg::bgcd_cmd_t  cmd,
  output bgcd_pkg::bgcd_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bgcd_pkg::bgcd_out_t  out_data
);
  import bgcd_pkg::*;

  localparam int KW = $clog2(VALUE_BITS);
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  logic [VALUE_BITS-1:0] a0, b0, a, b, g, rem, quo, acc;
  logic [KW-1:0]         k, cnt;
  logic                  ovf;

  logic [VALUE_BITS:0]   rem_sh, rem_sub;
  logic                  rem_ge;
  logic [VALUE_BITS+1:0] mul_sum;
  logic                  mul_over;
  logic                  a_gt_b;
  logic [VALUE_BITS-1:0] diff;
  bgcd_out_t             result;

  assign a_gt_b  = a > b;
  assign diff    = a_gt_b ? (a - b) : (b - a);
  assign rem_sh  = {rem, quo[VALUE_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, g};
  assign rem_sub = rem_sh - {1'b0, g};
  // MSB-first shift-and-add; the partial product only grows
  assign mul_sum  = {1'b0, acc, 1'b0} +
                    {2'b00, (quo[VALUE_BITS-1] ? b0 : {VALUE_BITS{1'b0}})};
  assign mul_over = mul_sum > {2'b00, VMAX};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a0 <= in_data.operand_a[VALUE_BITS-1:0];
      b0 <= in_data.operand_b[VALUE_BITS-1:0];
      a  <= in_data.operand_a[VALUE_BITS-1:0];
      b  <= in_data.operand_b[VALUE_BITS-1:0];
      k  <= '0;
    end else if (cmd.strip_step) begin
      a <= a >> 1;
      b <= b >> 1;
      k <= k + 1'b1;
    end else if (cmd.odd_step) begin
      a <= a >> 1;
    end else if (cmd.reduce_step) begin
      if (!b[0]) begin
        b <= b >> 1;
      end else begin
        if (a_gt_b) a <= b;
        b <= diff;
      end
    end

    if (cmd.div_init) begin
      g   <= a << k;
      rem <= '0;
      quo <= a0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      quo <= {quo[VALUE_BITS-2:0], rem_ge};
    end else if (cmd.mul_step) begin
      quo <= {quo[VALUE_BITS-2:0], 1'b0};
    end

    if (cmd.mul_init) begin
      acc <= '0;
      ovf <= 1'b0;
    end else if (cmd.mul_step) begin
      acc <= mul_sum[VALUE_BITS-1:0];
      if (mul_over) ovf <= 1'b1;
    end

    if (cmd.div_init || cmd.mul_init) begin
      cnt <= KW'(VALUE_BITS - 1);
    end else if (cmd.div_step || cmd.mul_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_comb begin
    if (a0 == '0 && b0 == '0) begin
      result.gcd_value = '0;
      result.lcm_value = '0;
      result.status    = STATUS_BOTH_ZERO;
    end else if (a0 == '0 || b0 == '0) begin
      result.gcd_value = FIELD_BITS'(a0 | b0);
      result.lcm_value = '0;
      result.status    = STATUS_OK;
    end else begin
      result.gcd_value = FIELD_BITS'(g);
      result.lcm_value = FIELD_BITS'(ovf ? VMAX : acc);
      result.status    = ovf ? STATUS_OVERFLOW : STATUS_OK;
    end
  end

  // output register: holds a finished transaction while the next one runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) out_data <= result;
  end

  assign stat.a_lsb    = a[0];
  assign stat.b_lsb    = b[0];
  assign stat.b_zero   = (b == '0);
  assign stat.op_zero  = (a0 == '0) || (b0 == '0);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.out_free = !out_valid || out_ready;

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bgcd_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;

  localparam logic [62:0] VMAX = '1;
  localparam logic [62:0] P62  = 63'h4000000000000000;

  typedef struct packed {
    bit          typed;
    logic [62:0] a;
    logic [62:0] b;
    bgcd_out_t   want;
  } stim_row_t;

  // Rows with typed set carry their own result; the rest go through the predictor.
  localparam stim_row_t DIRECTED [24] = '{
    '{1'b1, 63'd0, 63'd0, '{63'd0, 63'd0, STATUS_BOTH_ZERO}},
    '{1'b1, 63'd0, VMAX, '{VMAX, 63'd0, STATUS_OK}},
    '{1'b1, VMAX, 63'd0, '{VMAX, 63'd0, STATUS_OK}},
    '{1'b1, 63'd1, 63'd1, '{63'd1, 63'd1, STATUS_OK}},
    '{1'b1, VMAX, VMAX, '{VMAX, VMAX, STATUS_OK}},
    '{1'b1, VMAX, 63'd1, '{63'd1, VMAX, STATUS_OK}},
    '{1'b1, 63'd1, VMAX, '{63'd1, VMAX, STATUS_OK}},
    '{1'b1, VMAX, VMAX - 63'd1, '{63'd1, VMAX, STATUS_OVERFLOW}},
    '{1'b1, P62, P62, '{P62, P62, STATUS_OK}},
    '{1'b1, P62, 63'd3, '{63'd1, VMAX, STATUS_OVERFLOW}},
    '{1'b1, 63'd0, 63'd1, '{63'd1, 63'd0, STATUS_OK}},
    '{1'b1, 63'd5, 63'd0, '{63'd5, 63'd0, STATUS_OK}},
    '{1'b0, 63'd12, 63'd18, '0},
    '{1'b0, 63'd48, 63'd180, '0},
    '{1'b0, 63'd3 << 40, 63'd9 << 20, '0},
    '{1'b0, 63'd7919, 63'd104729, '0},
    '{1'b0, P62, 63'd1 << 31, '0},
    '{1'b0, 63'h5555555555555555, 63'h2AAAAAAAAAAAAAAA, '0},
    '{1'b0, 63'h2AAAAAAAAAAAAAAA, 63'h5555555555555555, '0},
    '{1'b0, 63'hFFFFFFFF, 63'h100000001, '0},
    '{1'b0, 63'd3037000499, 63'd3037000493, '0},
    '{1'b0, 63'd6, 63'd4, '0},
    '{1'b0, 63'd1, P62, '0},
    '{1'b0, 63'd2, 63'd2, '0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  bgcd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  bgcd_out_t out_data;

  bgcd_out_t expected_results[$];
  int        err_count   = 0;
  int        idle_cycles = 0;
  int        burst_left  = 1;
  int        ready_hold  = 0;

  binary_gcd_lcm_unit #(.VALUE_BITS(63)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // gcd by Euclid, lcm as (a / gcd) * b saturated at the top of the range
  function automatic bgcd_out_t gcd_lcm(logic [62:0] a, logic [62:0] b);
    bit [63:0] x, y, t, q;
    bgcd_out_t r;
    x = {1'b0, a};
    y = {1'b0, b};
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    r.gcd_value = x[62:0];
    r.lcm_value = '0;
    r.status    = STATUS_OK;
    if (a == 0 && b == 0) begin
      r.status = STATUS_BOTH_ZERO;
    end else if (a != 0 && b != 0) begin
      q = {1'b0, a} / x;
      if (q > {1'b0, VMAX} / {1'b0, b}) begin
        r.lcm_value = VMAX;
        r.status    = STATUS_OVERFLOW;
      end else begin
        t = q * {1'b0, b};
        r.lcm_value = t[62:0];
      end
    end
    return r;
  endfunction

  // Value of exactly w significant bits; w of zero gives one.
  function automatic logic [62:0] rand_bits(int w);
    bit [63:0] v;
    v = {$urandom, $urandom};
    if (w <= 0) return 63'd1;
    v = v >> (64 - w);
    v[w-1] = 1'b1;
    return v[62:0];
  endfunction

  task automatic push_item(input logic [62:0] a, input logic [62:0] b,
                           input bit typed, input bgcd_out_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{operand_a: a, operand_b: b};
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(typed ? want : gcd_lcm(a, b));
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string field, input logic [62:0] want,
                              input logic [62:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Receiver: long ready stretches, long stalls, and cycle-by-cycle toggling.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready  <= 1'b0;
          ready_hold <= $urandom_range(1, 30);
        end
        1: begin
          out_ready  <= 1'b1;
          ready_hold <= $urandom_range(20, 200);
        end
        default: begin
          out_ready  <= 1'($urandom_range(0, 1));
          ready_hold <= 0;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    bgcd_out_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transaction, gcd %0d lcm %0d status %0d",
                   $time, out_data.gcd_value, out_data.lcm_value, out_data.status);
        end else begin
          want = expected_results.pop_front();
          report_field("gcd_value", want.gcd_value, out_data.gcd_value);
          report_field("lcm_value", want.lcm_value, out_data.lcm_value);
          report_field("status", 63'(want.status), 63'(out_data.status));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("binary_gcd_lcm_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int          sel;
    logic [62:0] a, b, g;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      push_item(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // shared factor, often with a common power of two
        g = rand_bits($urandom_range(0, 20)) << $urandom_range(0, 12);
        a = g * rand_bits($urandom_range(0, 21));
        b = g * rand_bits($urandom_range(0, 21));
      end else if (sel < 60) begin
        a = 63'({$urandom, $urandom});
        b = 63'({$urandom, $urandom});
      end else if (sel < 80) begin
        a = rand_bits($urandom_range(1, 63));
        b = rand_bits($urandom_range(1, 63));
      end else if (sel < 82) begin
        a = '0;
        b = '0;
      end else if (sel < 88) begin
        a = '0;
        b = rand_bits($urandom_range(1, 63));
        if ($urandom_range(0, 1)) begin
          a = b;
          b = '0;
        end
      end else if (sel < 95) begin
        a = 63'd1 << $urandom_range(0, 62);
        b = (sel % 2 == 0) ? 63'd1 << $urandom_range(0, 62)
                           : rand_bits($urandom_range(1, 63));
      end else begin
        a = rand_bits($urandom_range(1, 31));
        b = a * rand_bits($urandom_range(0, 31));
        if ($urandom_range(0, 1)) begin
          g = a;
          a = b;
          b = g;
        end
      end
      push_item(a, b, 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("binary_gcd_lcm_unit: match");
    else
      $display("binary_gcd_lcm_unit: mismatch");
    $finish;
  end

endmodule
